FILE: rtl/lpif_pkg.sv
// Package for the line-preserving input FIFO.
// Holds the item types, operation codes and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package lpif_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] char_in;
    } request_t;

    typedef struct packed {
        logic       byte_taken;
        logic       read_valid;
        logic [7:0] read_char;
        logic [8:0] fill_level;
        logic       data_available;
    } response_t;

endpackage

FILE: rtl/line_preserving_input_fifo.sv
// Top level of the line-preserving input FIFO: ring pointers, fill count and result register.
// Depends on lpif_pkg and lpif_ram.
`timescale 1ns / 1ps

// Takes one item per clock: busy stays low, so an item is accepted whenever start is high.
// Each item gives one result, shown on response with done high in the cycle after
// the item is accepted; the receiver must take it in that cycle. The ring RAM's read port
// is registered: a get reads the oldest byte at the accepting edge and the byte appears
// with the result. A put stores at the tail when there is room; into a full ring a newline
// replaces the newest byte unless that byte is already a newline, and any other byte is
// dropped. A get on an empty ring returns read_valid low and changes nothing. The ring
// contents need no clearing after reset.
module line_preserving_input_fifo
    import lpif_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  request_t  request,
    output logic      done,
    output response_t response
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [ADDR_W-1:0] rd_ptr_reg,  rd_ptr_next;
    logic [ADDR_W-1:0] wr_ptr_reg,  wr_ptr_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic              last_nl_reg, last_nl_next;

    logic              done_reg;
    logic              taken_reg,   taken_next;
    logic              valid_reg,   valid_next;
    logic [8:0]        fill_reg,    fill_next;
    logic              avail_reg,   avail_next;

    logic              accept;
    logic              full;
    logic              empty;
    logic              do_store;
    logic              do_over;
    logic              do_pop;
    logic [ADDR_W-1:0] last_ptr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    assign last_ptr = (wr_ptr_reg == '0) ? ADDR_W'(DEPTH - 1) : wr_ptr_reg - 1'b1;

    assign do_store = accept && (request.opcode == OP_PUT) && !full;
    assign do_over  = accept && (request.opcode == OP_PUT) && full
                      && (request.char_in == NEWLINE_CODE) && !last_nl_reg;
    assign do_pop   = accept && (request.opcode == OP_GET) && !empty;

    assign ram_we    = do_store || do_over;
    assign ram_waddr = do_store ? wr_ptr_reg : last_ptr;
    assign ram_wdata = do_store ? request.char_in : NEWLINE_CODE;

    always_comb
    begin
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        count_next   = count_reg;
        last_nl_next = last_nl_reg;

        if (do_store)
        begin
            wr_ptr_next  = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next   = count_reg + 1'b1;
            last_nl_next = (request.char_in == NEWLINE_CODE);
        end
        else if (do_over)
        begin
            last_nl_next = 1'b1;
        end
        else if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end

        taken_next = do_store || do_over;
        valid_next = do_pop;
        fill_next  = 9'(count_next);
        avail_next = (count_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            count_reg   <= '0;
            last_nl_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            count_reg   <= count_next;
            last_nl_reg <= last_nl_next;
            done_reg    <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            taken_reg <= taken_next;
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            avail_reg <= avail_next;
        end
    end

    lpif_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign done                    = done_reg;
    assign response.byte_taken     = taken_reg;
    assign response.read_valid     = valid_reg;
    assign response.read_char      = valid_reg ? ram_rdata : 8'h00;
    assign response.fill_level     = fill_reg;
    assign response.data_available = avail_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above ring depth");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted item gave no result");

    a_taken_or_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(response.byte_taken && response.read_valid))
        else $error("result both stored and popped");

    a_avail_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (response.data_available == (count_reg != '0)))
        else $error("data available flag disagrees with fill count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not lower the fill count");
`endif

endmodule

FILE: rtl/lpif_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
